// ----- hdl/vfgd_pkg.sv -----
// shared types, constants and constant tables of the voice frame golay decoder
package vfgd_pkg;

    localparam int FRAME_BITS = 72;
    localparam int WORD_BITS  = 24;
    localparam int BLOCK_BITS = 23;
    localparam int SYN_BITS   = 11;
    localparam int DATA_BITS  = 12;
    localparam int LEAD_DEPTH = 2048;
    localparam int LCG_STEPS  = 24;

    localparam logic [11:0] SYN_POLY = 12'hc75;
    localparam logic [15:0] LCG_MUL  = 16'd173;
    localparam logic [15:0] LCG_ADD  = 16'd13849;

    typedef logic [BLOCK_BITS-1:0][SYN_BITS-1:0] col_tab_t;

    typedef struct packed {
        logic [1:0]            weight;
        logic [BLOCK_BITS-1:0] pattern;
    } leader_t;

    typedef leader_t [LEAD_DEPTH-1:0]               leader_tab_t;
    typedef logic [LCG_STEPS-1:0][DATA_BITS-1:0]    lcg_mul_tab_t;
    typedef logic [LCG_STEPS-1:0][15:0]             lcg_add_tab_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] first_word;
        logic [DATA_BITS-1:0] second_word;
        logic [WORD_BITS-1:0] third_word;
        logic [3:0]           error_count;
    } result_t;

    // syndrome of a single-bit block, long division by the generator
    function automatic logic [SYN_BITS-1:0] unit_syn(int a);
        logic [BLOCK_BITS-1:0] blk;
        blk = BLOCK_BITS'(1) << a;
        for (int k = BLOCK_BITS - 1; k >= SYN_BITS; k--)
        begin
            if (blk[k])
            begin
                blk = blk ^ (BLOCK_BITS'(SYN_POLY) << (k - SYN_BITS));
            end
        end
        return blk[SYN_BITS-1:0];
    endfunction

    function automatic col_tab_t build_cols();
        col_tab_t tab;
        for (int a = 0; a < BLOCK_BITS; a++)
        begin
            tab[a] = unit_syn(a);
        end
        return tab;
    endfunction

    localparam col_tab_t SYN_COLS = build_cols();

    // syndrome is linear: xor of the column syndromes of the set bits
    function automatic logic [SYN_BITS-1:0] syn_of(logic [BLOCK_BITS-1:0] blk);
        logic [SYN_BITS-1:0] s;
        s = '0;
        for (int a = 0; a < BLOCK_BITS; a++)
        begin
            if (blk[a])
            begin
                s = s ^ SYN_COLS[a];
            end
        end
        return s;
    endfunction

    // perfect code: the 2048 patterns of weight 0..3 cover every syndrome once
    function automatic leader_tab_t build_leaders();
        leader_tab_t tab;
        tab = '0;
        for (int a = 0; a < BLOCK_BITS; a++)
        begin
            tab[SYN_COLS[a]].weight  = 2'd1;
            tab[SYN_COLS[a]].pattern = BLOCK_BITS'(1) << a;
            for (int b = a + 1; b < BLOCK_BITS; b++)
            begin
                tab[SYN_COLS[a] ^ SYN_COLS[b]].weight  = 2'd2;
                tab[SYN_COLS[a] ^ SYN_COLS[b]].pattern =
                    (BLOCK_BITS'(1) << a) | (BLOCK_BITS'(1) << b);
                for (int c = b + 1; c < BLOCK_BITS; c++)
                begin
                    tab[SYN_COLS[a] ^ SYN_COLS[b] ^ SYN_COLS[c]].weight  = 2'd3;
                    tab[SYN_COLS[a] ^ SYN_COLS[b] ^ SYN_COLS[c]].pattern =
                        (BLOCK_BITS'(1) << a) | (BLOCK_BITS'(1) << b) |
                        (BLOCK_BITS'(1) << c);
                end
            end
        end
        return tab;
    endfunction

    localparam leader_tab_t LEADERS = build_leaders();

    // lcg after t+1 steps: x = mul[t] * x0 + add[t] mod 2^16
    function automatic lcg_mul_tab_t build_lcg_mul();
        lcg_mul_tab_t tab;
        logic [31:0]  p;
        logic [15:0]  m;
        m = 16'd1;
        for (int t = 0; t < LCG_STEPS; t++)
        begin
            p      = 32'(m) * 32'(LCG_MUL);
            m      = p[15:0];
            tab[t] = m[DATA_BITS-1:0];
        end
        return tab;
    endfunction

    function automatic lcg_add_tab_t build_lcg_add();
        lcg_add_tab_t tab;
        logic [31:0]  p;
        logic [15:0]  c;
        c = 16'd0;
        for (int t = 0; t < LCG_STEPS; t++)
        begin
            p      = 32'(c) * 32'(LCG_MUL) + 32'(LCG_ADD);
            c      = p[15:0];
            tab[t] = c;
        end
        return tab;
    endfunction

    localparam lcg_mul_tab_t LCG_MUL_TAB = build_lcg_mul();
    localparam lcg_add_tab_t LCG_ADD_TAB = build_lcg_add();

endpackage

// ----- hdl/vfgd_ifs.sv -----
// frame and result channel interfaces of the voice frame golay decoder
interface vfgd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] frame_high;
    logic [7:0]  frame_low;

    modport source (output valid, frame_high, frame_low, input ready);
    modport sink   (input valid, frame_high, frame_low, output ready);
endinterface

interface vfgd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] first_word;
    logic [11:0] second_word;
    logic [23:0] third_word;
    logic [3:0]  error_count;

    modport source (output valid, first_word, second_word, third_word, error_count,
                    input ready);
    modport sink   (input valid, first_word, second_word, third_word, error_count,
                    output ready);
endinterface

// ----- hdl/voice_frame_golay_fec_decoder_core.sv -----
// voice frame golay(24,12) decoder top level, seven-stage pipeline
//
// Takes one 72-bit voice frame per beat (frame_high = bytes 0..7, frame_low =
// byte 8), splits it into three 24-bit words, corrects word A with an extended
// golay(24,12) decoder, descrambles word B with a whitening pattern seeded by
// the decoded A data, corrects it the same way and passes word C through.
// error_count is the number of corrected bits plus one per parity mismatch,
// summed over both words (0..8). A new frame can be taken every clock while the
// result side is not stalled. Every stage has its own valid bit and enable, so
// empty stages fill up while the result side stalls and frames keep entering
// until the pipe is full. The stages follow the chain syndrome -> coset leader
// lookup -> correction, which runs twice, once for word A and once for word B,
// with the whitening multiplies in a stage of their own between the two. The
// coset leader table (2048 entries of weight and error pattern) is a constant
// table read with a registered output, one copy for each word. The whitening
// pattern is 24 lcg steps folded into 24 independent 12x12 constant multiplies.
// Frames carry no state and there is no init time.
module voice_frame_golay_fec_decoder_core (
    input  logic              clk,
    input  logic              rst_n,
    vfgd_in_if.sink           frame,
    vfgd_out_if.source        result
);

    localparam int NUM_STAGES = 7;

    // stage valid bits and enables; enable means the stage may load this cycle
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;
    logic [NUM_STAGES-1:0] upstream_valid;

    // deinterleave: frame bit i (msb first) -> word (i%6)/2, row i/6
    logic [vfgd_pkg::FRAME_BITS-1:0]   frame_bits;
    wire  [2:0][vfgd_pkg::WORD_BITS-1:0] dil_word;

    assign frame_bits = {frame.frame_high, frame.frame_low};

    for (genvar i = 0; i < vfgd_pkg::FRAME_BITS; i++)
    begin : g_dil
        localparam int ROW  = i / 6;
        localparam int WSEL = (i % 6) / 2;
        localparam int POS  = (i % 2 == 0) ? (23 - ROW) : (11 - ROW);
        assign dil_word[WSEL][POS] = frame_bits[vfgd_pkg::FRAME_BITS-1-i];
    end

    // ---------------------------------------------------------------------
    // handshake and valid chain
    // ---------------------------------------------------------------------
    // the last stage is the output register
    assign upstream_valid = {valid_reg[NUM_STAGES-2:0], frame.valid};

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            valid_next[k] = stage_en[k] ? upstream_valid[k] : valid_reg[k];
        end
    end

    assign frame.ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: split words, syndrome of word A
    // ---------------------------------------------------------------------
    logic [vfgd_pkg::WORD_BITS-1:0] s1_wa_reg, s1_wb_reg, s1_wc_reg;
    logic [vfgd_pkg::SYN_BITS-1:0]  s1_syn_reg;
    logic [vfgd_pkg::SYN_BITS-1:0]  s1_syn_next;

    assign s1_syn_next = vfgd_pkg::syn_of(dil_word[0][vfgd_pkg::WORD_BITS-1:1]);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_wa_reg  <= dil_word[0];
            s1_wb_reg  <= dil_word[1];
            s1_wc_reg  <= dil_word[2];
            s1_syn_reg <= s1_syn_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: coset leader lookup for word A
    // ---------------------------------------------------------------------
    logic [vfgd_pkg::WORD_BITS-1:0] s2_wa_reg, s2_wb_reg, s2_wc_reg;
    vfgd_pkg::leader_t              s2_lead_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_wa_reg   <= s1_wa_reg;
            s2_wb_reg   <= s1_wb_reg;
            s2_wc_reg   <= s1_wc_reg;
            s2_lead_reg <= vfgd_pkg::LEADERS[s1_syn_reg];
        end
    end

    // ---------------------------------------------------------------------
    // stage 3: correct word A, its data and error count
    // ---------------------------------------------------------------------
    logic [vfgd_pkg::BLOCK_BITS-1:0] fix_a;
    logic                            par_a;
    logic [2:0]                      s3_erra_next;
    logic [vfgd_pkg::DATA_BITS-1:0]  s3_da_reg;
    logic [2:0]                      s3_erra_reg;
    logic [vfgd_pkg::WORD_BITS-1:0]  s3_wb_reg, s3_wc_reg;

    assign fix_a        = s2_wa_reg[vfgd_pkg::WORD_BITS-1:1] ^ s2_lead_reg.pattern;
    assign par_a        = (^fix_a) ^ s2_wa_reg[0];
    assign s3_erra_next = 3'(s2_lead_reg.weight) + 3'(par_a);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_da_reg   <= fix_a[22:11];
            s3_erra_reg <= s3_erra_next;
            s3_wb_reg   <= s2_wb_reg;
            s3_wc_reg   <= s2_wc_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 4: whitening pattern from decoded A, descramble word B
    // ---------------------------------------------------------------------
    // seed is data << 4, so only the low 12 bits of each product matter
    logic [2*vfgd_pkg::DATA_BITS-1:0] wh_prod [vfgd_pkg::LCG_STEPS];
    logic [15:0]                      wh_sum  [vfgd_pkg::LCG_STEPS];
    logic [vfgd_pkg::WORD_BITS-1:0]   wh_pat;
    logic [vfgd_pkg::WORD_BITS-1:0]   s4_wb_reg, s4_wc_reg;
    logic [vfgd_pkg::DATA_BITS-1:0]   s4_da_reg;
    logic [2:0]                       s4_erra_reg;

    always_comb
    begin
        for (int t = 0; t < vfgd_pkg::LCG_STEPS; t++)
        begin
            wh_prod[t] = s3_da_reg * vfgd_pkg::LCG_MUL_TAB[t];
            wh_sum[t]  = {wh_prod[t][vfgd_pkg::DATA_BITS-1:0], 4'b0000}
                         + vfgd_pkg::LCG_ADD_TAB[t];
            // first step gives the msb
            wh_pat[vfgd_pkg::LCG_STEPS-1-t] = wh_sum[t][15];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s4_wb_reg   <= s3_wb_reg ^ wh_pat;
            s4_wc_reg   <= s3_wc_reg;
            s4_da_reg   <= s3_da_reg;
            s4_erra_reg <= s3_erra_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 5: syndrome of descrambled word B
    // ---------------------------------------------------------------------
    logic [vfgd_pkg::WORD_BITS-1:0] s5_wb_reg, s5_wc_reg;
    logic [vfgd_pkg::DATA_BITS-1:0] s5_da_reg;
    logic [2:0]                     s5_erra_reg;
    logic [vfgd_pkg::SYN_BITS-1:0]  s5_syn_reg;
    logic [vfgd_pkg::SYN_BITS-1:0]  s5_syn_next;

    assign s5_syn_next = vfgd_pkg::syn_of(s4_wb_reg[vfgd_pkg::WORD_BITS-1:1]);

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s5_wb_reg   <= s4_wb_reg;
            s5_wc_reg   <= s4_wc_reg;
            s5_da_reg   <= s4_da_reg;
            s5_erra_reg <= s4_erra_reg;
            s5_syn_reg  <= s5_syn_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 6: coset leader lookup for word B
    // ---------------------------------------------------------------------
    logic [vfgd_pkg::WORD_BITS-1:0] s6_wb_reg, s6_wc_reg;
    logic [vfgd_pkg::DATA_BITS-1:0] s6_da_reg;
    logic [2:0]                     s6_erra_reg;
    vfgd_pkg::leader_t              s6_lead_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            s6_wb_reg   <= s5_wb_reg;
            s6_wc_reg   <= s5_wc_reg;
            s6_da_reg   <= s5_da_reg;
            s6_erra_reg <= s5_erra_reg;
            s6_lead_reg <= vfgd_pkg::LEADERS[s5_syn_reg];
        end
    end

    // ---------------------------------------------------------------------
    // stage 7: correct word B, total error count, output register
    // ---------------------------------------------------------------------
    logic [vfgd_pkg::BLOCK_BITS-1:0] fix_b;
    logic                            par_b;
    vfgd_pkg::result_t               out_next;
    vfgd_pkg::result_t               out_reg;

    assign fix_b = s6_wb_reg[vfgd_pkg::WORD_BITS-1:1] ^ s6_lead_reg.pattern;
    assign par_b = (^fix_b) ^ s6_wb_reg[0];

    always_comb
    begin
        out_next.first_word  = s6_da_reg;
        out_next.second_word = fix_b[22:11];
        out_next.third_word  = s6_wc_reg;
        out_next.error_count = 4'(s6_erra_reg) + 4'(s6_lead_reg.weight) + 4'(par_b);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid       = valid_reg[NUM_STAGES-1];
    assign result.first_word  = out_reg.first_word;
    assign result.second_word = out_reg.second_word;
    assign result.third_word  = out_reg.third_word;
    assign result.error_count = out_reg.error_count;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // a free result side lets the whole pipe advance, so frames are taken
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> frame.ready)
        else $error("frame side stalled while result side is free");

    // an accepted frame always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready) |=> valid_reg[0])
        else $error("accepted frame lost at pipeline entry");

    // looked-up pattern weight matches the pattern
    a_leader_weight: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> ($countones(s2_lead_reg.pattern) == 32'(s2_lead_reg.weight)))
        else $error("coset leader weight does not match pattern");

    // correction of word A clears its syndrome
    a_fix_clears_syn: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> (vfgd_pkg::syn_of(fix_a) == '0))
        else $error("corrected word A has nonzero syndrome");

    // both words together never exceed eight
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.error_count <= 4'd8))
        else $error("error count out of range");

endmodule

// ----- tb/sv/tb_voice_frame_golay_fec_decoder_core.sv -----
// self-checking testbench of the voice frame golay(24,12) decoder core
module tb_voice_frame_golay_fec_decoder_core;

    // generator of the (23,12) golay code, x^11+x^10+x^6+x^5+x^4+x^2+1
    localparam bit [11:0] GEN_POLY     = 12'hc75;
    // whitening lcg: x <- 173*x + 13849 mod 2^16
    localparam bit [31:0] WHITE_MUL    = 32'd173;
    localparam bit [31:0] WHITE_ADD    = 32'd13849;
    // pipeline is seven deep, leave plenty of slack after the last result
    localparam int        TAIL_CYCLES  = 20;
    localparam int        MAX_REPORTS  = 10;
    localparam int        HOLD_CYCLES  = 80;
    localparam int        TIMEOUT_TIME = 2000000;

    // how the result side drives ready
    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

    typedef struct packed {
        bit [11:0] first_word;
        bit [11:0] second_word;
        bit [23:0] third_word;
        bit [3:0]  error_count;
    } decode_t;

    logic clk;
    logic rst_n;

    vfgd_in_if  frame_bus ();
    vfgd_out_if result_bus ();

    voice_frame_golay_fec_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_bus),
        .result (result_bus)
    );

    // coset leader of every syndrome, rebuilt here by brute force
    bit [22:0]  coset_pattern [0:2047];
    bit [1:0]   coset_weight  [0:2047];

    decode_t    awaited_decodes [$];
    int         mismatch_count;

    // sender burst state
    bit         sender_gaps;
    int         burst_left;

    // receiver control, the hold request is taken over by the ready process
    sink_mode_t sink_mode;
    int         hold_request;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // remainder of the 23-bit block modulo the generator
    function automatic bit [10:0] block_syndrome(bit [22:0] blk);
        for (int k = 22; k >= 11; k--)
        begin
            if (blk[k])
            begin
                blk = blk ^ (23'(GEN_POLY) << (k - 11));
            end
        end
        return blk[10:0];
    endfunction

    // all 2048 patterns of weight 0..3 land on distinct syndromes (perfect code)
    task automatic build_coset_table();
        bit [22:0] pat;
        for (int s = 0; s < 2048; s++)
        begin
            coset_pattern[s] = '0;
            coset_weight[s]  = 2'd0;
        end
        for (int a = 0; a < 23; a++)
        begin
            pat = 23'(1) << a;
            coset_pattern[block_syndrome(pat)] = pat;
            coset_weight[block_syndrome(pat)]  = 2'd1;
            for (int b = a + 1; b < 23; b++)
            begin
                pat = (23'(1) << a) | (23'(1) << b);
                coset_pattern[block_syndrome(pat)] = pat;
                coset_weight[block_syndrome(pat)]  = 2'd2;
                for (int c = b + 1; c < 23; c++)
                begin
                    pat = (23'(1) << a) | (23'(1) << b) | (23'(1) << c);
                    coset_pattern[block_syndrome(pat)] = pat;
                    coset_weight[block_syndrome(pat)]  = 2'd3;
                end
            end
        end
    endtask

    // extended golay word: block in bits 23..1, overall check in bit 0
    function automatic void golay_correct(input bit [23:0] w, output bit [11:0] data,
                                          output bit [3:0] errs);
        bit [22:0] fixed;
        bit [10:0] syn;
        syn   = block_syndrome(w[23:1]);
        fixed = w[23:1] ^ coset_pattern[syn];
        errs  = 4'(coset_weight[syn]) + 4'((^fixed) != w[0]);
        data  = fixed[22:11];
    endfunction

    // 24 lcg steps from data<<4, bit 15 of each step, first step is bit 23
    function automatic bit [23:0] whiten_mask(bit [11:0] seed);
        bit [15:0] x;
        bit [31:0] prod;
        bit [23:0] pat;
        x = {seed, 4'b0};
        for (int j = 0; j < 24; j++)
        begin
            prod       = 32'(x) * WHITE_MUL + WHITE_ADD;
            x          = prod[15:0];
            pat[23-j]  = x[15];
        end
        return pat;
    endfunction

    // frame bit i (msb first) sits in word (i mod 6)/2, at 23-i/6 (even i)
    // or 11-i/6 (odd i)
    function automatic int word_pos(int i);
        return (i % 2 == 0) ? 23 - i / 6 : 11 - i / 6;
    endfunction

    function automatic void split_frame(input bit [71:0] f, output bit [23:0] wa,
                                        output bit [23:0] wb, output bit [23:0] wc);
        wa = '0;
        wb = '0;
        wc = '0;
        for (int i = 0; i < 72; i++)
        begin
            case ((i % 6) / 2)
                0:       wa[word_pos(i)] = f[71-i];
                1:       wb[word_pos(i)] = f[71-i];
                default: wc[word_pos(i)] = f[71-i];
            endcase
        end
    endfunction

    function automatic bit [71:0] merge_frame(bit [23:0] wa, bit [23:0] wb, bit [23:0] wc);
        bit [71:0] f;
        for (int i = 0; i < 72; i++)
        begin
            case ((i % 6) / 2)
                0:       f[71-i] = wa[word_pos(i)];
                1:       f[71-i] = wb[word_pos(i)];
                default: f[71-i] = wc[word_pos(i)];
            endcase
        end
        return f;
    endfunction

    function automatic decode_t decode_frame(bit [63:0] hi, bit [7:0] lo);
        decode_t   d;
        bit [23:0] wa, wb, wc;
        bit [3:0]  ea, eb;
        split_frame({hi, lo}, wa, wb, wc);
        golay_correct(wa, d.first_word, ea);
        // word b is descrambled with a pattern seeded by the corrected word a
        golay_correct(wb ^ whiten_mask(d.first_word), d.second_word, eb);
        d.third_word  = wc;
        d.error_count = ea + eb;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // clean codeword: parity remainder in the low 11 bits, overall check at bit 0
    function automatic bit [23:0] golay_encode(bit [11:0] data);
        bit [22:0] blk;
        blk = {data, 11'b0};
        blk = blk | 23'(block_syndrome(blk));
        return {blk, ^blk};
    endfunction

    // flip n distinct block bits, and the check bit when asked
    function automatic bit [23:0] corrupt_word(bit [23:0] w, int n, bit chk);
        bit [23:0] flips;
        int        placed;
        int        p;
        flips  = '0;
        placed = 0;
        while (placed < n)
        begin
            p = $urandom_range(1, 23);
            if (!flips[p])
            begin
                flips[p] = 1'b1;
                placed++;
            end
        end
        flips[0] = chk;
        return w ^ flips;
    endfunction

    // random error weight per word, mostly correctable, now and then four
    function automatic int pick_flips();
        int r;
        r = $urandom_range(0, 15);
        if (r < 4)
            return 0;
        else if (r < 8)
            return 1;
        else if (r < 11)
            return 2;
        else if (r < 14)
            return 3;
        return 4;
    endfunction

    // ------------------------------------------------------------------
    // frame side: one beat per call, valid stays high through a burst
    // ------------------------------------------------------------------

    task automatic send_frame(input bit [63:0] hi, input bit [7:0] lo);
        int gap;
        if (burst_left == 0)
        begin
            gap        = sender_gaps ? $urandom_range(0, 8) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                frame_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        frame_bus.valid      <= 1'b1;
        frame_bus.frame_high <= hi;
        frame_bus.frame_low  <= lo;
        do
            @(posedge clk);
        while (!frame_bus.ready);
        burst_left--;
        awaited_decodes.push_back(decode_frame(hi, lo));
    endtask

    // build a frame from two coded words with chosen damage and a raw third word
    task automatic send_coded(input bit [11:0] a_data, input bit [11:0] b_data,
                              input bit [23:0] c_word, input int a_flips, input bit a_chk,
                              input int b_flips, input bit b_chk);
        bit [23:0] wa, wb;
        bit [11:0] seed;
        bit [3:0]  unused_errs;
        bit [71:0] f;
        wa = corrupt_word(golay_encode(a_data), a_flips, a_chk);
        // the block whitens b with whatever a decodes to, so do the same here
        golay_correct(wa, seed, unused_errs);
        wb = corrupt_word(golay_encode(b_data), b_flips, b_chk) ^ whiten_mask(seed);
        f  = merge_frame(wa, wb, c_word);
        send_frame(f[71:8], f[7:0]);
    endtask

    // drop valid and wait until every result is back, then the pipeline tail
    task automatic wait_results_drained();
        @(negedge clk);
        frame_bus.valid <= 1'b0;
        burst_left = 0;
        while (awaited_decodes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side: ready pattern plus an optional long hold-off
    // ------------------------------------------------------------------

    initial
    begin
        int hold_left;
        int phase;
        hold_left        = 0;
        phase            = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            phase = (phase + 1) % 7;
            if (hold_left > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (sink_mode)
                    SINK_OPEN:     result_bus.ready <= 1'b1;
                    SINK_RANDOM:   result_bus.ready <= ($urandom_range(0, 99) < 70);
                    SINK_PERIODIC: result_bus.ready <= (phase >= 3);
                    default:       result_bus.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // checker: each result beat against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        decode_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (awaited_decodes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result beat: first=%h second=%h third=%h errs=%0d",
                             result_bus.first_word, result_bus.second_word,
                             result_bus.third_word, result_bus.error_count);
            end
            else
            begin
                want = awaited_decodes.pop_front();
                if (want.first_word  !== result_bus.first_word  ||
                    want.second_word !== result_bus.second_word ||
                    want.third_word  !== result_bus.third_word  ||
                    want.error_count !== result_bus.error_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: first %h/%h second %h/%h third %h/%h errs %0d/%0d",
                                 want.first_word, result_bus.first_word,
                                 want.second_word, result_bus.second_word,
                                 want.third_word, result_bus.third_word,
                                 want.error_count, result_bus.error_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes and checkerboards, no idling on either side
    task automatic test_corner_frames();
        sink_mode   = SINK_OPEN;
        sender_gaps = 1'b0;
        send_frame(64'h0, 8'h00);
        send_frame({64{1'b1}}, 8'hff);
        send_frame({64{1'b1}}, 8'h00);
        send_frame(64'h0, 8'hff);
        send_frame(64'haaaa_aaaa_aaaa_aaaa, 8'h55);
        send_frame(64'h5555_5555_5555_5555, 8'haa);
        wait_results_drained();
    endtask

    // every error weight per word, check bit alone, the count of eight and
    // a beyond-capacity word that gets miscorrected
    task automatic test_error_weights();
        sink_mode   = SINK_RANDOM;
        sender_gaps = 1'b1;
        send_coded(12'h000, 12'h000, 24'h000000, 0, 1'b0, 0, 1'b0);
        send_coded(12'hfff, 12'hfff, 24'hffffff, 0, 1'b0, 0, 1'b0);
        send_coded(12'($urandom), 12'($urandom), 24'($urandom), 1, 1'b0, 0, 1'b0);
        send_coded(12'($urandom), 12'($urandom), 24'($urandom), 0, 1'b0, 1, 1'b0);
        send_coded(12'($urandom), 12'($urandom), 24'($urandom), 2, 1'b0, 2, 1'b0);
        send_coded(12'($urandom), 12'($urandom), 24'($urandom), 3, 1'b0, 3, 1'b0);
        // only the overall check bit is wrong
        send_coded(12'($urandom), 12'($urandom), 24'($urandom), 0, 1'b1, 0, 1'b0);
        send_coded(12'($urandom), 12'($urandom), 24'($urandom), 0, 1'b0, 0, 1'b1);
        // three block errors plus a bad check bit in both words gives eight
        send_coded(12'hfff, 12'h000, 24'h000000, 3, 1'b1, 3, 1'b1);
        send_coded(12'h000, 12'hfff, 24'hffffff, 3, 1'b1, 3, 1'b1);
        // four errors decode to a wrong codeword, which also skews b's whitening
        send_coded(12'($urandom), 12'($urandom), 24'($urandom), 4, 1'b0, 4, 1'b1);
        send_coded(12'($urandom), 12'($urandom), 24'($urandom), 4, 1'b1, 2, 1'b0);
        wait_results_drained();
    endtask

    // well-formed frames with random data and damage; an unbroken stretch first
    task automatic test_random_codewords(input int count);
        sink_mode   = SINK_OPEN;
        sender_gaps = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 5)
            begin
                sink_mode   = SINK_RANDOM;
                sender_gaps = 1'b1;
            end
            send_coded(12'($urandom), 12'($urandom), 24'($urandom),
                       pick_flips(), 1'($urandom), pick_flips(), 1'($urandom));
        end
        wait_results_drained();
    endtask

    // raw random frames, mostly weight-three syndromes
    task automatic test_random_frames(input int count);
        sink_mode   = SINK_PERIODIC;
        sender_gaps = 1'b1;
        for (int n = 0; n < count; n++)
            send_frame({$urandom, $urandom}, 8'($urandom));
        wait_results_drained();
    endtask

    // result side holds off long enough for the pipe to fill and stall input
    task automatic test_backpressure(input int count);
        sink_mode    = SINK_OPEN;
        sender_gaps  = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < count; n++)
            send_coded(12'($urandom), 12'($urandom), 24'($urandom),
                       pick_flips(), 1'($urandom), pick_flips(), 1'($urandom));
        wait_results_drained();
    endtask

    initial
    begin
        TIMEOUT_WAIT: #(TIMEOUT_TIME);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        frame_bus.valid      = 1'b0;
        frame_bus.frame_high = '0;
        frame_bus.frame_low  = '0;
        mismatch_count       = 0;
        sender_gaps          = 1'b0;
        burst_left           = 0;
        sink_mode            = SINK_OPEN;
        hold_request         = 0;
        build_coset_table();

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_corner_frames();
        test_error_weights();
        test_random_codewords(500);
        test_random_frames(150);
        test_backpressure(40);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/vfgd_pkg.sv
hdl/vfgd_ifs.sv
hdl/voice_frame_golay_fec_decoder_core.sv
tb/sv/tb_voice_frame_golay_fec_decoder_core.sv
